/* rtl/mpct_pkg.sv */
package mpct_pkg;

  // Coordinate range: both axes saturate to 0 .. CoordMax
  localparam int unsigned CoordBits = 12;
  localparam int unsigned SumBits   = CoordBits + 2;
  localparam logic [CoordBits-1:0] CoordMax = {CoordBits{1'b1}};

  // Operation codes carried on the input tuser
  localparam logic OpByte   = 1'b0;
  localparam logic OpSetPos = 1'b1;

  // Position of the next byte within a packet
  localparam logic [1:0] IdxHeader = 2'd0;
  localparam logic [1:0] IdxDeltaX = 2'd1;
  localparam logic [1:0] IdxDeltaY = 2'd2;

  // Header bit that marks the first byte of a packet, and the button bits
  localparam logic [7:0] SyncMask   = 8'h08;
  localparam logic [2:0] ButtonMask = 3'h7;

  typedef struct packed {
    logic                 operation;
    logic [7:0]           data_byte;
    logic [CoordBits-1:0] new_x;
    logic [CoordBits-1:0] new_y;
  } item_t;

  typedef struct packed {
    logic [CoordBits-1:0] cursor_x;
    logic [CoordBits-1:0] cursor_y;
    logic [2:0]           button_bits;
    logic                 packet_done;
    logic                 byte_dropped;
  } result_t;

  // Saturate a signed sum to the coordinate range
  function automatic logic [CoordBits-1:0] clamp_coord(input logic signed [SumBits-1:0] v);
    logic [CoordBits-1:0] r;
    if (v < $signed({SumBits{1'b0}})) begin
      r = '0;
    end else if (v > $signed({2'b00, CoordMax})) begin
      r = CoordMax;
    end else begin
      r = v[CoordBits-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/mpct_in_reg.sv */
module mpct_in_reg
  import mpct_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // Take a new transaction when empty or when the held one moves on
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the payload until it is consumed
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/mpct_core.sv */
module mpct_core
  import mpct_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [1:0]           byte_index_q, byte_index_d;
  logic [7:0]           header_q, header_d;
  logic [7:0]           delta_x_q, delta_x_d;
  logic [CoordBits-1:0] pos_x_q, pos_x_d;
  logic [CoordBits-1:0] pos_y_q, pos_y_d;
  logic [2:0]           buttons_q, buttons_d;
  logic                 done;
  logic                 dropped;
  logic signed [SumBits-1:0] sum_x;
  logic signed [SumBits-1:0] sum_y;

  // Apply the stored X delta and the negated incoming Y delta
  assign sum_x = $signed({2'b00, pos_x_q})
               + $signed({{(SumBits-8){delta_x_q[7]}}, delta_x_q});
  assign sum_y = $signed({2'b00, pos_y_q})
               - $signed({{(SumBits-8){item_i.data_byte[7]}}, item_i.data_byte});

  // Next state for one transaction
  always_comb begin
    byte_index_d = byte_index_q;
    header_d     = header_q;
    delta_x_d    = delta_x_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    buttons_d    = buttons_q;
    done         = 1'b0;
    dropped      = 1'b0;
    if (item_i.operation == OpSetPos) begin
      pos_x_d = item_i.new_x;
      pos_y_d = item_i.new_y;
    end else begin
      case (byte_index_q)
        IdxDeltaX: begin
          delta_x_d    = item_i.data_byte;
          byte_index_d = IdxDeltaY;
        end
        IdxDeltaY: begin
          byte_index_d = IdxHeader;
          buttons_d    = header_q[2:0] & ButtonMask;
          pos_x_d      = clamp_coord(sum_x);
          pos_y_d      = clamp_coord(sum_y);
          done         = 1'b1;
        end
        default: begin
          // Drop a first byte without the sync bit to resynchronise
          if ((item_i.data_byte & SyncMask) != 8'h00) begin
            header_d     = item_i.data_byte;
            byte_index_d = IdxDeltaX;
          end else begin
            byte_index_d = IdxHeader;
            dropped      = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= IdxHeader;
      header_q     <= '0;
      delta_x_q    <= '0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      buttons_q    <= '0;
    end else if (advance_i) begin
      byte_index_q <= byte_index_d;
      header_q     <= header_d;
      delta_x_q    <= delta_x_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      buttons_q    <= buttons_d;
    end
  end

  always_comb begin
    result_o.cursor_x     = pos_x_d;
    result_o.cursor_y     = pos_y_d;
    result_o.button_bits  = buttons_d;
    result_o.packet_done  = done;
    result_o.byte_dropped = dropped;
  end

endmodule

/* rtl/mpct_out_reg.sv */
module mpct_out_reg
  import mpct_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    ready_i,
  output logic    valid_o,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  // Fill on load, empty when the downstream side takes the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

/* rtl/mouse_packet_cursor_tracker_top.sv */
// Pipeline: the input transaction is held in the input register, and its result is
// registered in the result register before it is offered downstream.
// Throughput: one transaction per cycle unless the output stalls; the per-byte update
// is a single pass of add-and-saturate logic between the input and result registers.
// Reset: asynchronous, active low; clears the byte index, stored header and X delta,
// cursor position and buttons to zero, and empties both registers.
module mouse_packet_cursor_tracker_top
  import mpct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] data_byte, [19:8] new_x, [31:20] new_y
  input  logic [31:0] s_axis_tdata_i,
  // [0] operation
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [11:0] cursor_x, [23:12] cursor_y, [26:24] button_bits, [31:27] zero
  output logic [31:0] m_axis_tdata_o,
  // [0] packet_done, [1] byte_dropped
  output logic [1:0]  m_axis_tuser_o
);

  item_t   item_in;
  item_t   item_q;
  result_t result_next;
  result_t result_q;
  logic    in_valid;
  logic    out_valid;
  logic    advance;

  always_comb begin
    item_in.operation = s_axis_tuser_i;
    item_in.data_byte = s_axis_tdata_i[7:0];
    item_in.new_x     = s_axis_tdata_i[19:8];
    item_in.new_y     = s_axis_tdata_i[31:20];
  end

  // Move the held item on when the result register is free or draining
  assign advance = in_valid && (!out_valid || m_axis_tready_i);

  mpct_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (item_in),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (item_q)
  );

  mpct_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .result_o  (result_next)
  );

  mpct_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result_next),
    .ready_i  (m_axis_tready_i),
    .valid_o  (out_valid),
    .result_o (result_q)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {5'b0, result_q.button_bits, result_q.cursor_y, result_q.cursor_x};
  assign m_axis_tuser_o  = {result_q.byte_dropped, result_q.packet_done};

`ifndef ASSERT_OFF
  // A completed packet and a dropped byte never come from the same transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("packet_done and byte_dropped both set");

  // An item that moves on always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid)
    else $error("advanced item lost");

  // Back-pressure only when both registers are full and the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid && out_valid && !m_axis_tready_i))
    else $error("input stalled without cause");
`endif

endmodule
